FILE: src/rlss_pkg.sv
// Shared types, letter classes and ending tables for the light Russian stemmer.
package rlss_pkg;

  // Word length counter saturates here
  localparam int MAX_WORD_LEN = 255;
  localparam int LEN_W        = $clog2(MAX_WORD_LEN + 1);
  // Characters kept in the tail window
  localparam int WIN_CHARS    = 6;
  localparam int CHAR_W       = 16;
  localparam int STEM_W       = 8;

  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CHAR_W-1:0] char_t;

  // Each character is reduced to the class of the letter it is; only letters
  // that occur in some ending, and n for the double-n rule, get a class of their own.
  localparam int CLS_W = 5;
  typedef logic [CLS_W-1:0] cls_t;
  typedef cls_t [WIN_CHARS-1:0] win_t;

  localparam cls_t CL_OTHER = 5'd0;
  localparam cls_t CL_A     = 5'd1;
  localparam cls_t CL_V     = 5'd2;
  localparam cls_t CL_G     = 5'd3;
  localparam cls_t CL_E     = 5'd4;
  localparam cls_t CL_I     = 5'd5;
  localparam cls_t CL_IK    = 5'd6;
  localparam cls_t CL_M     = 5'd7;
  localparam cls_t CL_N     = 5'd8;
  localparam cls_t CL_O     = 5'd9;
  localparam cls_t CL_R     = 5'd10;
  localparam cls_t CL_U     = 5'd11;
  localparam cls_t CL_KH    = 5'd12;
  localparam cls_t CL_Y     = 5'd13;
  localparam cls_t CL_SOFT  = 5'd14;
  localparam cls_t CL_YU    = 5'd15;
  localparam cls_t CL_YA    = 5'd16;
  localparam cls_t CL_YO    = 5'd17;

  localparam char_t CH_A    = 16'h0430;
  localparam char_t CH_V    = 16'h0432;
  localparam char_t CH_G    = 16'h0433;
  localparam char_t CH_E    = 16'h0435;
  localparam char_t CH_I    = 16'h0438;
  localparam char_t CH_IK   = 16'h0439;
  localparam char_t CH_M    = 16'h043c;
  localparam char_t CH_N    = 16'h043d;
  localparam char_t CH_O    = 16'h043e;
  localparam char_t CH_R    = 16'h0440;
  localparam char_t CH_U    = 16'h0443;
  localparam char_t CH_KH   = 16'h0445;
  localparam char_t CH_Y    = 16'h044b;
  localparam char_t CH_SOFT = 16'h044c;
  localparam char_t CH_YU   = 16'h044e;
  localparam char_t CH_YA   = 16'h044f;
  localparam char_t CH_YO   = 16'h0451;

  function automatic cls_t char_class(input char_t c);
    cls_t k;
    case (c)
      CH_A:    k = CL_A;
      CH_V:    k = CL_V;
      CH_G:    k = CL_G;
      CH_E:    k = CL_E;
      CH_I:    k = CL_I;
      CH_IK:   k = CL_IK;
      CH_M:    k = CL_M;
      CH_N:    k = CL_N;
      CH_O:    k = CL_O;
      CH_R:    k = CL_R;
      CH_U:    k = CL_U;
      CH_KH:   k = CL_KH;
      CH_Y:    k = CL_Y;
      CH_SOFT: k = CL_SOFT;
      CH_YU:   k = CL_YU;
      CH_YA:   k = CL_YA;
      CH_YO:   k = CL_YO;
      default: k = CL_OTHER;
    endcase
    return k;
  endfunction

  // Ending tables in reading order (last entry is the word's final letter)
  localparam int N_END4 = 2;
  localparam int N_END3 = 15;
  localparam int N_END2 = 30;
  localparam int N_END1 = 9;

  localparam cls_t ENDS4 [N_END4][4] = '{
    '{CL_I, CL_YA, CL_M, CL_I}, '{CL_O, CL_YA, CL_M, CL_I}
  };

  localparam cls_t ENDS3 [N_END3][3] = '{
    '{CL_I, CL_YA, CL_M}, '{CL_I, CL_YA, CL_KH}, '{CL_O, CL_YA, CL_KH},
    '{CL_YA, CL_M, CL_I}, '{CL_O, CL_YA, CL_M}, '{CL_O, CL_SOFT, CL_V},
    '{CL_A, CL_M, CL_I}, '{CL_E, CL_G, CL_O}, '{CL_E, CL_M, CL_U},
    '{CL_E, CL_R, CL_I}, '{CL_I, CL_M, CL_I}, '{CL_O, CL_G, CL_O},
    '{CL_O, CL_M, CL_U}, '{CL_Y, CL_M, CL_I}, '{CL_O, CL_E, CL_V}
  };

  localparam cls_t ENDS2 [N_END2][2] = '{
    '{CL_A, CL_YA}, '{CL_YA, CL_YA}, '{CL_YA, CL_KH}, '{CL_YU, CL_YU},
    '{CL_A, CL_KH}, '{CL_E, CL_YU}, '{CL_I, CL_KH}, '{CL_I, CL_YA},
    '{CL_I, CL_YU}, '{CL_SOFT, CL_V}, '{CL_O, CL_YU}, '{CL_U, CL_YU},
    '{CL_YA, CL_M}, '{CL_Y, CL_KH}, '{CL_E, CL_YA}, '{CL_A, CL_M},
    '{CL_E, CL_M}, '{CL_E, CL_IK}, '{CL_YO, CL_M}, '{CL_E, CL_V},
    '{CL_I, CL_IK}, '{CL_I, CL_M}, '{CL_O, CL_E}, '{CL_O, CL_IK},
    '{CL_O, CL_M}, '{CL_O, CL_V}, '{CL_Y, CL_E}, '{CL_Y, CL_IK},
    '{CL_Y, CL_M}, '{CL_M, CL_I}
  };

  localparam cls_t ENDS1 [N_END1] = '{
    CL_A, CL_E, CL_I, CL_O, CL_U, CL_IK, CL_Y, CL_YA, CL_SOFT
  };

endpackage

FILE: src/rlss_cell.sv
// One tail window cell: holds a letter class and passes it to the next cell.
module rlss_cell (
  input  logic               clk,
  input  logic               shift_en,
  input  rlss_pkg::cls_t     cls_in,
  output rlss_pkg::cls_t     cls_out
);
  import rlss_pkg::*;

  cls_t cls_r;
  cls_t cls_nxt;

  // load from the left neighbor on every accepted character
  always_comb begin
    cls_nxt = shift_en ? cls_in : cls_r;
  end

  always_ff @(posedge clk) begin
    cls_r <= cls_nxt;
  end

  assign cls_out = cls_r;

endmodule

FILE: src/rlss_match.sv
// Ending match and normalization over the tail window; gives the stem length.
module rlss_match (
  input  rlss_pkg::win_t                   win,
  input  rlss_pkg::len_t                   word_len,
  output logic [rlss_pkg::STEM_W-1:0]      stem_length
);
  import rlss_pkg::*;

  logic        hit4, hit3, hit2, hit1;
  logic [2:0]  cut;
  len_t        len_cut;
  len_t        len_fin;
  cls_t        last_c, prev_c;
  logic        drop;
  logic [LEN_W+STEM_W-1:0] len_wide;

  // parallel compare against every ending of each set
  always_comb begin
    hit4 = 1'b0;
    hit3 = 1'b0;
    hit2 = 1'b0;
    hit1 = 1'b0;
    for (int e = 0; e < N_END4; e++) begin
      if (win[3] == ENDS4[e][0] && win[2] == ENDS4[e][1] &&
          win[1] == ENDS4[e][2] && win[0] == ENDS4[e][3]) begin
        hit4 = 1'b1;
      end
    end
    for (int e = 0; e < N_END3; e++) begin
      if (win[2] == ENDS3[e][0] && win[1] == ENDS3[e][1] &&
          win[0] == ENDS3[e][2]) begin
        hit3 = 1'b1;
      end
    end
    for (int e = 0; e < N_END2; e++) begin
      if (win[1] == ENDS2[e][0] && win[0] == ENDS2[e][1]) begin
        hit2 = 1'b1;
      end
    end
    for (int e = 0; e < N_END1; e++) begin
      if (win[0] == ENDS1[e]) begin
        hit1 = 1'b1;
      end
    end
  end

  // longest ending first, each behind its length guard
  always_comb begin
    if (word_len > len_t'(6) && hit4) begin
      cut = 3'd4;
    end else if (word_len > len_t'(5) && hit3) begin
      cut = 3'd3;
    end else if (word_len > len_t'(4) && hit2) begin
      cut = 3'd2;
    end else if (word_len > len_t'(3) && hit1) begin
      cut = 3'd1;
    end else begin
      cut = 3'd0;
    end
    len_cut = word_len - len_t'(cut);
  end

  // letters just ahead of the removed ending
  always_comb begin
    case (cut)
      3'd0: begin
        last_c = win[0];
        prev_c = win[1];
      end
      3'd1: begin
        last_c = win[1];
        prev_c = win[2];
      end
      3'd2: begin
        last_c = win[2];
        prev_c = win[3];
      end
      3'd3: begin
        last_c = win[3];
        prev_c = win[4];
      end
      3'd4: begin
        last_c = win[4];
        prev_c = win[5];
      end
      default: begin
        last_c = win[0];
        prev_c = win[1];
      end
    endcase
  end

  // drop soft sign, final i, or one n of a double n
  always_comb begin
    drop = (len_cut > len_t'(3)) &&
           (last_c == CL_SOFT || last_c == CL_I ||
            (last_c == CL_N && prev_c == CL_N));
    len_fin     = drop ? (len_cut - len_t'(1)) : len_cut;
    len_wide    = {{STEM_W{1'b0}}, len_fin};
    stem_length = len_wide[STEM_W-1:0];
  end

endmodule

FILE: src/russian_light_suffix_stemmer_unit.sv
// Top level of the light Russian suffix stemmer: cell row, length count, result register.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------
//   in      | input     | in_tvalid/tready   | in_tdata = char_code, in_tlast = last_char
//   out     | output    | out_tvalid/tready  | out_tdata = stem_length
//
// One character is taken per cycle while in_tready is high. The edge that accepts
// the last character of a word loads the window cells and the length snapshot;
// the ending match then passes into the result register once that register is
// free, and the stem length appears there.
// rst_n is synchronous, active low, and clears the handshake state and length.
// A result held by a stalled consumer stalls input only while a second finished
// word waits behind it.
module russian_light_suffix_stemmer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] char_code
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [7:0] stem_length
);
  import rlss_pkg::*;

  logic  in_acc;
  logic  load_out;
  logic  pend_r, pend_nxt;
  logic  out_valid_r, out_valid_nxt;
  logic [STEM_W-1:0] out_data_r, out_data_nxt;
  len_t  len_r, len_nxt;
  len_t  len_inc;
  len_t  snap_len_r, snap_len_nxt;
  win_t  win;
  cls_t  cls_head;
  logic [STEM_W-1:0] stem_len;

  // handshake: a finished word moves to the result register when it is free
  assign load_out  = pend_r && (!out_valid_r || out_tready);
  assign in_tready = !pend_r || load_out;
  assign in_acc    = in_tvalid && in_tready;

  assign cls_head = char_class(in_tdata);

  // row of window cells, newest letter in cell 0
  for (genvar g = 0; g < WIN_CHARS; g++) begin : g_cell
    if (g == 0) begin : g_head
      rlss_cell u_cell (
        .clk      (clk),
        .shift_en (in_acc),
        .cls_in   (cls_head),
        .cls_out  (win[g])
      );
    end else begin : g_body
      rlss_cell u_cell (
        .clk      (clk),
        .shift_en (in_acc),
        .cls_in   (win[g-1]),
        .cls_out  (win[g])
      );
    end
  end

  rlss_match u_match (
    .win         (win),
    .word_len    (snap_len_r),
    .stem_length (stem_len)
  );

  // saturating length count, captured at the last character
  always_comb begin
    len_inc      = (len_r == len_t'(MAX_WORD_LEN)) ? len_r : len_r + len_t'(1);
    len_nxt      = len_r;
    snap_len_nxt = snap_len_r;
    pend_nxt     = pend_r;
    if (load_out) begin
      pend_nxt = 1'b0;
    end
    if (in_acc) begin
      if (in_tlast) begin
        len_nxt      = '0;
        snap_len_nxt = len_inc;
        pend_nxt     = 1'b1;
      end else begin
        len_nxt = len_inc;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = stem_len;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_len_r <= snap_len_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: verif/russian_light_suffix_stemmer_unit_tb.sv
// Self-checking testbench for the light Russian suffix stemmer: stem lengths against a predictor.
module russian_light_suffix_stemmer_unit_tb;
  import rlss_pkg::*;

  // Ending sets in reading order, first letter in the top bits
  localparam logic [63:0] CUT4_TAILS [2] = '{
    {CH_I, CH_YA, CH_M, CH_I}, {CH_O, CH_YA, CH_M, CH_I}
  };
  localparam logic [47:0] CUT3_TAILS [15] = '{
    {CH_I, CH_YA, CH_M}, {CH_I, CH_YA, CH_KH}, {CH_O, CH_YA, CH_KH},
    {CH_YA, CH_M, CH_I}, {CH_O, CH_YA, CH_M}, {CH_O, CH_SOFT, CH_V},
    {CH_A, CH_M, CH_I}, {CH_E, CH_G, CH_O}, {CH_E, CH_M, CH_U},
    {CH_E, CH_R, CH_I}, {CH_I, CH_M, CH_I}, {CH_O, CH_G, CH_O},
    {CH_O, CH_M, CH_U}, {CH_Y, CH_M, CH_I}, {CH_O, CH_E, CH_V}
  };
  localparam logic [31:0] CUT2_TAILS [30] = '{
    {CH_A, CH_YA}, {CH_YA, CH_YA}, {CH_YA, CH_KH}, {CH_YU, CH_YU},
    {CH_A, CH_KH}, {CH_E, CH_YU}, {CH_I, CH_KH}, {CH_I, CH_YA},
    {CH_I, CH_YU}, {CH_SOFT, CH_V}, {CH_O, CH_YU}, {CH_U, CH_YU},
    {CH_YA, CH_M}, {CH_Y, CH_KH}, {CH_E, CH_YA}, {CH_A, CH_M},
    {CH_E, CH_M}, {CH_E, CH_IK}, {CH_YO, CH_M}, {CH_E, CH_V},
    {CH_I, CH_IK}, {CH_I, CH_M}, {CH_O, CH_E}, {CH_O, CH_IK},
    {CH_O, CH_M}, {CH_O, CH_V}, {CH_Y, CH_E}, {CH_Y, CH_IK},
    {CH_Y, CH_M}, {CH_M, CH_I}
  };
  localparam logic [15:0] CUT1_TAILS [9] = '{
    CH_A, CH_E, CH_I, CH_O, CH_U, CH_IK, CH_Y, CH_YA, CH_SOFT
  };

  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 5000;
  localparam int RAND_CHARS  = 820;

  // Stem predictor and store of expected stem lengths
  class stem_scoreboard;
    char_t       win [WIN_CHARS];
    int unsigned word_len;
    logic [7:0]  stems_due [$];
    int          errors;
    int          chars_seen;
    int          stems_checked;
    int          cut_hist [5];
    int          norm_drops;

    function new();
      foreach (win[i]) win[i] = '0;
      word_len = 0;
      errors = 0;
      chars_seen = 0;
      stems_checked = 0;
      norm_drops = 0;
      foreach (cut_hist[i]) cut_hist[i] = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("ERROR @%0t: %s", $time, msg);
    endtask

    function int outstanding();
      return stems_due.size();
    endfunction

    // Accepted character: shift into the window, predict on the last one
    function void note_char(char_t c, logic last);
      int unsigned len;
      int          cut;
      char_t       lc;
      char_t       pc;
      chars_seen++;
      for (int i = WIN_CHARS - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = c;
      if (word_len < MAX_WORD_LEN) word_len++;
      if (!last) return;
      len = word_len;
      cut = 0;
      if (len > 6)
        foreach (CUT4_TAILS[i])
          if ({win[3], win[2], win[1], win[0]} == CUT4_TAILS[i]) cut = 4;
      if (cut == 0 && len > 5)
        foreach (CUT3_TAILS[i])
          if ({win[2], win[1], win[0]} == CUT3_TAILS[i]) cut = 3;
      if (cut == 0 && len > 4)
        foreach (CUT2_TAILS[i])
          if ({win[1], win[0]} == CUT2_TAILS[i]) cut = 2;
      if (cut == 0 && len > 3)
        foreach (CUT1_TAILS[i])
          if (win[0] == CUT1_TAILS[i]) cut = 1;
      cut_hist[cut]++;
      len -= cut;
      // normalization: soft sign, final i, or second n of a double n
      if (len > 3) begin
        lc = win[cut];
        pc = win[cut+1];
        if (lc == CH_SOFT || lc == CH_I || (lc == CH_N && pc == CH_N)) begin
          len--;
          norm_drops++;
        end
      end
      stems_due.push_back(8'(len));
      foreach (win[i]) win[i] = '0;
      word_len = 0;
    endfunction

    // Accepted result word against the oldest expectation
    task check_stem(logic [7:0] got);
      logic [7:0] want;
      if (stems_due.size() == 0) begin
        report($sformatf("stem_length %0d with no word pending", got));
      end else begin
        want = stems_due.pop_front();
        stems_checked++;
        if (got !== want)
          report($sformatf("stem_length got %0d want %0d", got, want));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] char_code
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] stem_length

  stem_scoreboard sb = new();

  bit    tx_steady = 0;
  bit    rx_steady = 0;
  bit    hold_req = 0;
  int    words_sent = 0;
  int    idle_cycles = 0;
  char_t word_q [$];

  russian_light_suffix_stemmer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Cyrillic letter that occurs in no ending
  function automatic char_t CH_B_LIKE();
    return 16'h0431;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic char_t rand_letter();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return char_t'($urandom_range(0, 65535));
    if (r == 1) return CH_YO;
    return char_t'(16'h0430 + $urandom_range(0, 31));
  endfunction

  // Append an ending given in reading order, n letters
  function automatic void push_tail(logic [63:0] e, int n);
    for (int k = n - 1; k >= 0; k--) word_q.push_back(e[k*16 +: 16]);
  endfunction

  // Random word: mostly stem + optional normalization letter + case ending
  function automatic void build_word();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    word_q.delete();
    if (kind < 72) begin
      n = $urandom_range(0, 7);
      repeat (n) word_q.push_back(rand_letter());
      case ($urandom_range(0, 5))
        0: word_q.push_back(CH_SOFT);
        1: word_q.push_back(CH_I);
        2: begin
          word_q.push_back(CH_N);
          word_q.push_back(CH_N);
        end
        default: ;
      endcase
      case ($urandom_range(0, 4))
        4: push_tail(CUT4_TAILS[$urandom_range(0, 1)], 4);
        3: push_tail(64'(CUT3_TAILS[$urandom_range(0, 14)]), 3);
        2: push_tail(64'(CUT2_TAILS[$urandom_range(0, 29)]), 2);
        1: push_tail(64'(CUT1_TAILS[$urandom_range(0, 8)]), 1);
        default: ;
      endcase
    end else if (kind < 88) begin
      // letters drawn from the one-letter endings, now and then ORed with the code of n
      n = $urandom_range(1, 10);
      repeat (n) word_q.push_back(CUT1_TAILS[$urandom_range(0, 8)] |
                                  (($urandom_range(0, 3) == 0) ? CH_N : 16'h0));
    end else begin
      // arbitrary code units
      n = $urandom_range(1, 8);
      repeat (n) word_q.push_back(char_t'($urandom_range(0, 65535)));
    end
    if (word_q.size() == 0) word_q.push_back(rand_letter());
  endfunction

  task automatic send_char(char_t c, logic last);
    int g;
    g = tx_steady ? 0 : gap_len();
    if (g > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_word();
    foreach (word_q[i]) send_char(word_q[i], i == word_q.size() - 1);
    words_sent++;
  endtask

  // Drop valid and wait until every pending stem has come back
  task automatic drain();
    @(negedge clk) in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, steady stretches, one long hold-off
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end
      g = rx_steady ? 0 : gap_len();
      if (g > 0) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end
      @(negedge clk) out_tready <= 1'b1;
    end
  end

  // Accepted transfers on both channels
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_char(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) sb.check_stem(out_tdata);
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("FAIL russian_light_suffix_stemmer_unit");
      $finish;
    end
  end

  initial begin
    int base;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed words
    word_q = '{CH_A};                               // single letter
    send_word();
    word_q = '{16'hFFFF};                           // single, all bits set
    send_word();
    word_q = '{CH_B_LIKE(), CH_YA, CH_M, CH_I};     // short: only 1-letter cut allowed
    send_word();
    word_q = '{16'h0000, 16'h8000, CH_N, CH_N};     // double n, no ending
    send_word();
    word_q = '{16'h0431, 16'h0432, 16'h0434, CH_O, CH_YA, CH_M, CH_I};
    send_word();
    word_q = '{16'h0000, 16'h7FFF, 16'h0041};       // non-Cyrillic codes
    send_word();
    // overlong word: length saturates, ending still seen on the true tail
    word_q.delete();
    repeat (MAX_WORD_LEN + 2) word_q.push_back(rand_letter());
    word_q.push_back(CH_SOFT);
    push_tail(64'(CUT3_TAILS[7]), 3);
    send_word();

    // Random words
    base = sb.chars_seen;
    while (sb.chars_seen - base < RAND_CHARS) begin
      if (words_sent % 25 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      if (words_sent == 40) begin
        // receiver holds off while short words keep coming
        tx_steady = 1;
        hold_req = 1;
        repeat (30) begin
          word_q.delete();
          repeat ($urandom_range(1, 3)) word_q.push_back(rand_letter());
          send_word();
        end
        tx_steady = 0;
      end
      if (words_sent == 100) drain();
      build_word();
      send_word();
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.outstanding() != 0)
      sb.report($sformatf("%0d stem lengths never arrived", sb.outstanding()));
    $display("covered %0d words, %0d characters, %0d stem lengths checked",
             words_sent, sb.chars_seen, sb.stems_checked);
    $display("endings cut by size 0..4: %0d %0d %0d %0d %0d, normalization drops: %0d",
             sb.cut_hist[0], sb.cut_hist[1], sb.cut_hist[2], sb.cut_hist[3],
             sb.cut_hist[4], sb.norm_drops);
    if (sb.errors == 0) begin
      $display("PASS russian_light_suffix_stemmer_unit");
    end else begin
      $display("FAIL russian_light_suffix_stemmer_unit");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/rlss_pkg.sv
src/rlss_cell.sv
src/rlss_match.sv
src/russian_light_suffix_stemmer_unit.sv
verif/russian_light_suffix_stemmer_unit_tb.sv
